// ===== sv/ffq_pkg.sv =====
// ----------------------------------------------------------------------------
// ffq_pkg
// shared constants, result codes and controller/datapath interface structs
// for the fast-forward ring queue engine
// ----------------------------------------------------------------------------
package ffq_pkg;

  // ring depth; positions are the low bits of a counter, so a power of two
  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LIMIT_W = 6;
  localparam int unsigned SLOT_W  = 8;

  localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RESET = LIMIT_W'(20);

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_GAP       = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic accept;       // word taken at the port
    logic deq_read;     // take head ticket, read its cell
    logic enq_gap;      // tail cell occupied: mark gap, advance tail
    logic enq_store;    // tail cell free: store word, advance tail
    logic enq_give_up;  // probe limit reached
    logic deq_finish;   // judge the read cell, emit result
  } ffq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tail_full;
    logic probes_done;
  } ffq_stat_t;

endpackage

// ===== sv/ffq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffq_ctrl
// sequencing state machine: walks enqueue probes, runs dequeue read/check
// ----------------------------------------------------------------------------
module ffq_ctrl
  import ffq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      operation,
  input  ffq_stat_t stat,
  output logic      busy,
  output ffq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ,
    S_DEQ
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept   = 1'b1;
          cmd.deq_read = (operation == OP_DEQ);
          state_next   = (operation == OP_DEQ) ? S_DEQ : S_ENQ;
        end
      end
      S_ENQ: begin
        if (stat.probes_done) begin
          cmd.enq_give_up = 1'b1;
          state_next      = S_IDLE;
        end else if (stat.tail_full) begin
          cmd.enq_gap = 1'b1;
        end else begin
          cmd.enq_store = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DEQ: begin
        cmd.deq_finish = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ===== sv/ffq_dp.sv =====
// ----------------------------------------------------------------------------
// ffq_dp
// cell flags, cell memories, ring counters, probe limit and result registers
// ----------------------------------------------------------------------------
module ffq_dp
  import ffq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ffq_cmd_t            cmd,
  output ffq_stat_t           stat,
  input  logic                cfg_write,
  input  logic [LIMIT_W-1:0]  cfg_data,
  input  logic signed [WORD_W-1:0] value,
  output logic                done,
  output logic [1:0]          status,
  output logic signed [WORD_W-1:0] data_out,
  output logic [SLOT_W-1:0]   slot,
  output logic [WORD_W-1:0]   ticket
);

  logic [LIMIT_W-1:0]     probe_limit;
  logic [LIMIT_W-1:0]     probes;
  logic [WORD_W-1:0]      tail;
  logic [WORD_W-1:0]      head;
  logic [WORD_W-1:0]      last_tick;
  logic [WORD_W-1:0]      deq_tick;
  logic [WORD_W-1:0]      value_q;
  logic [QUEUE_DEPTH-1:0] full_bits;
  logic [QUEUE_DEPTH-1:0] gap_bits;

  logic [WORD_W-1:0] ticket_mem [QUEUE_DEPTH];
  logic [WORD_W-1:0] gap_mem    [QUEUE_DEPTH];
  logic [WORD_W-1:0] data_mem   [QUEUE_DEPTH];
  logic [WORD_W-1:0] rd_ticket;
  logic [WORD_W-1:0] rd_gap;
  logic [WORD_W-1:0] rd_data;

  logic [IDX_W-1:0]  tail_pos;
  logic [IDX_W-1:0]  head_pos;
  logic [IDX_W-1:0]  deq_pos;
  logic [WORD_W-1:0] gap_dist;
  logic              deq_match;
  logic              deq_gap;

  assign tail_pos = tail[IDX_W-1:0];
  assign head_pos = head[IDX_W-1:0];
  assign deq_pos  = deq_tick[IDX_W-1:0];

  assign stat.tail_full   = full_bits[tail_pos];
  assign stat.probes_done = (probes == probe_limit);

  // serial-number compare: gap at or past ticket
  assign gap_dist  = rd_gap - deq_tick;
  assign deq_match = full_bits[deq_pos] && (rd_ticket == deq_tick);
  assign deq_gap   = gap_bits[deq_pos] && !gap_dist[WORD_W-1];

  // cell memories
  always_ff @(posedge clk) begin
    if (cmd.enq_store) begin
      ticket_mem[tail_pos] <= tail;
      data_mem[tail_pos]   <= value_q;
    end
    if (cmd.enq_gap) begin
      gap_mem[tail_pos] <= tail;
    end
    if (cmd.deq_read) begin
      rd_ticket <= ticket_mem[head_pos];
      rd_gap    <= gap_mem[head_pos];
      rd_data   <= data_mem[head_pos];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value_q <= value;
    end
    if (cmd.deq_read) begin
      deq_tick <= head;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_limit <= PROBE_LIMIT_RESET;
      probes      <= '0;
      tail        <= '0;
      head        <= '0;
      last_tick   <= '0;
      full_bits   <= '0;
      gap_bits    <= '0;
      done        <= 1'b0;
      status      <= ST_OK;
      data_out    <= '0;
      slot        <= '0;
      ticket      <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        probe_limit <= cfg_data;
      end
      if (cmd.accept) begin
        probes    <= '0;
        last_tick <= tail;
      end
      if (cmd.deq_read) begin
        head <= head + 1'b1;
      end
      if (cmd.enq_gap) begin
        gap_bits[tail_pos] <= 1'b1;
        tail               <= tail + 1'b1;
        probes             <= probes + 1'b1;
        last_tick          <= tail;
      end
      if (cmd.enq_store) begin
        full_bits[tail_pos] <= 1'b1;
        tail                <= tail + 1'b1;
        done                <= 1'b1;
        status              <= ST_OK;
        data_out            <= '0;
        slot                <= SLOT_W'(tail_pos);
        ticket              <= tail;
      end
      if (cmd.enq_give_up) begin
        done     <= 1'b1;
        status   <= ST_FULL;
        data_out <= '0;
        slot     <= SLOT_W'(last_tick[IDX_W-1:0]);
        ticket   <= last_tick;
      end
      if (cmd.deq_finish) begin
        done   <= 1'b1;
        slot   <= SLOT_W'(deq_pos);
        ticket <= deq_tick;
        if (deq_match) begin
          full_bits[deq_pos] <= 1'b0;
          status             <= ST_OK;
          data_out           <= rd_data;
        end else if (deq_gap) begin
          status   <= ST_GAP;
          data_out <= '0;
        end else begin
          status   <= ST_NOT_READY;
          data_out <= '0;
        end
      end
    end
  end

endmodule

// ===== sv/ffq_ring_queue_engine.sv =====
// ----------------------------------------------------------------------------
// ffq_ring_queue_engine
// fast-forward ring queue: one producer, many consumers, ticketed cells with
// gap marks so a consumer can skip cells the producer stepped over
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   ------------------------  ------------------------------------
//  command   start / busy              operation, value
//  result    done (one-cycle strobe)   status, data_out, slot, ticket
//  config    cfg_write                 cfg_data (enqueue probe limit)
//
//  a command word is taken at a rising edge with start high and busy low
//  dequeue: registered read of the head cell, then the check and the result
//  enqueue: one cell probe per cycle from the tail, gap marks on occupied
//    cells, until it stores the word or gives up as full at the probe limit
//  done pulses for exactly one cycle; the receiver cannot stall it
//  rst is synchronous; cell flags clear at once, no clearing pass needed
//
module ffq_ring_queue_engine
  import ffq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // command word
  input  logic                     start,
  output logic                     busy,
  input  logic                     operation,
  input  logic signed [WORD_W-1:0] value,
  // result word
  output logic                     done,
  output logic [1:0]               status,
  output logic signed [WORD_W-1:0] data_out,
  output logic [SLOT_W-1:0]        slot,
  output logic [WORD_W-1:0]        ticket,
  // probe limit register
  input  logic                     cfg_write,
  input  logic [LIMIT_W-1:0]       cfg_data
);

  ffq_cmd_t  cmd;   // sequencing commands to the datapath
  ffq_stat_t stat;  // tail cell occupancy and probe count status

  // controller: idle, enqueue probe walk, dequeue check
  ffq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  // datapath: counters, cell flags and memories, result registers
  ffq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .value     (value),
    .done      (done),
    .status    (status),
    .data_out  (data_out),
    .slot      (slot),
    .ticket    (ticket)
  );

endmodule

// ===== dv/ffq_ring_queue_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffq_ring_queue_engine_test
// self-checking regression for the fast-forward ring queue engine: a
// cycle-free queue predictor computes the outcome of every command word,
// a monitor compares each result strobe field by field, and the stimulus
// walks from directed corner cases through ring overflow into random traffic
// ----------------------------------------------------------------------------
module ffq_ring_queue_engine_test;
  import ffq_pkg::*;

  // cycles with nothing moving before the run is declared hung; the slowest
  // legal gap is a long sender pause followed by a 63-probe enqueue
  localparam int unsigned STALL_LIMIT = 2000;
  // quiet cycles after the last result, well past the longest enqueue
  localparam int unsigned TAIL_CYCLES = 80;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data;
    logic [SLOT_W-1:0]        slot;
    logic [WORD_W-1:0]        ticket;
  } ring_outcome_t;

  // dut ports; all inputs driven to known values from time zero
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     operation = OP_ENQ;
  logic signed [WORD_W-1:0] value = '0;
  logic                     done;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] data_out;
  logic [SLOT_W-1:0]        slot;
  logic [WORD_W-1:0]        ticket;
  logic                     cfg_write = 1'b0;
  logic [LIMIT_W-1:0]       cfg_data = '0;

  // queue predictor state: one copy of every cell plus both counters and the limit
  logic                ring_full      [QUEUE_DEPTH];
  logic [WORD_W-1:0]   ring_ticket    [QUEUE_DEPTH];
  logic                ring_gap_valid [QUEUE_DEPTH];
  logic [WORD_W-1:0]   ring_gap       [QUEUE_DEPTH];
  logic [WORD_W-1:0]   ring_data      [QUEUE_DEPTH];
  logic [WORD_W-1:0]   tail_ticket;
  logic [WORD_W-1:0]   head_ticket;
  logic [LIMIT_W-1:0]  probe_limit;

  // outcomes predicted at acceptance, retired by the result monitor
  ring_outcome_t awaited_outcomes[$];

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  int unsigned steady_left    = 0;
  int unsigned enq_count      = 0;
  int unsigned deq_count      = 0;
  int unsigned limit_writes   = 0;
  int unsigned outcome_tally[4] = '{0, 0, 0, 0};

  ffq_ring_queue_engine uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .value     (value),
    .done      (done),
    .status    (status),
    .data_out  (data_out),
    .slot      (slot),
    .ticket    (ticket),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  task automatic ring_clear();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ring_full[i]      = 1'b0;
      ring_gap_valid[i] = 1'b0;
      ring_ticket[i]    = '0;
      ring_gap[i]       = '0;
      ring_data[i]      = '0;
    end
    tail_ticket = '0;
    head_ticket = '0;
    probe_limit = PROBE_LIMIT_RESET;
  endtask

  // apply one accepted command word to the predictor and queue its outcome
  task automatic ring_apply(input logic op, input logic [WORD_W-1:0] val);
    ring_outcome_t outcome;
    int unsigned   pos;
    int unsigned   probes;
    logic          stored;
    outcome = '0;
    if (op == OP_ENQ) begin
      enq_count++;
      // with a zero limit nothing is probed and the tail is reported as is
      outcome.status = ST_FULL;
      outcome.slot   = SLOT_W'(tail_ticket % QUEUE_DEPTH);
      outcome.ticket = tail_ticket;
      stored = 1'b0;
      probes = 0;
      while (!stored && probes < probe_limit) begin
        pos            = tail_ticket % QUEUE_DEPTH;
        outcome.slot   = SLOT_W'(pos);
        outcome.ticket = tail_ticket;
        if (ring_full[pos]) begin
          // occupied: leave a gap mark so consumers can skip this ticket
          ring_gap_valid[pos] = 1'b1;
          ring_gap[pos]       = tail_ticket;
          probes++;
        end else begin
          ring_data[pos]   = val;
          ring_ticket[pos] = tail_ticket;
          ring_full[pos]   = 1'b1;
          outcome.status   = ST_OK;
          stored           = 1'b1;
        end
        tail_ticket = tail_ticket + 1'b1;
      end
    end else begin
      deq_count++;
      pos            = head_ticket % QUEUE_DEPTH;
      outcome.slot   = SLOT_W'(pos);
      outcome.ticket = head_ticket;
      if (ring_full[pos] && ring_ticket[pos] == head_ticket) begin
        // matching ticket frees the cell, its gap mark stays
        ring_full[pos] = 1'b0;
        outcome.data   = ring_data[pos];
        outcome.status = ST_OK;
      end else if (ring_gap_valid[pos] &&
                   (ring_gap[pos] - head_ticket) < 32'h8000_0000) begin
        // serial-number compare: gap at or past this ticket
        outcome.status = ST_GAP;
      end else begin
        outcome.status = ST_NOT_READY;
      end
      // the ticket is consumed whatever the cell held
      head_ticket = head_ticket + 1'b1;
    end
    outcome_tally[outcome.status]++;
    awaited_outcomes.push_back(outcome);
  endtask

  // --------------------------------------------------------------------------
  // result monitor and watchdog
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // outputs sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin : check_results
    ring_outcome_t want;
    if (!rst && done) begin
      if (awaited_outcomes.size() == 0) begin
        flag_mismatch($sformatf("result with none pending, status %0d ticket %0d",
                                status, ticket));
      end else begin
        want = awaited_outcomes.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("ticket %0d status %0d, want %0d",
                                  want.ticket, status, want.status));
        if (data_out !== want.data)
          flag_mismatch($sformatf("ticket %0d data_out %h, want %h",
                                  want.ticket, data_out, want.data));
        if (slot !== want.slot)
          flag_mismatch($sformatf("ticket %0d slot %0d, want %0d",
                                  want.ticket, slot, want.slot));
        if (ticket !== want.ticket)
          flag_mismatch($sformatf("ticket field %0d, want %0d", ticket, want.ticket));
      end
    end
  end

  // any accepted command or result strobe counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("ffq_ring_queue_engine regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // mostly back to back or short pauses, now and then a long one, and
  // occasional stretches with no pause at all
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) steady_left = $urandom_range(10, 40);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // present one command word and hold it until the engine takes it;
  // start stays high on return so the next word can follow with no bubble
  task automatic issue_word(input logic op, input logic [WORD_W-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    value     <= val;
    do @(posedge clk); while (busy);
    ring_apply(op, val);
  endtask

  // stop issuing and wait for every pending result; each word gives one
  // result, so the engine is idle once the last one has come
  task automatic settle();
    start <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_probe_limit(input logic [LIMIT_W-1:0] limit);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_write <= 1'b0;
    probe_limit = limit;
    limit_writes++;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // value extremes in and out in ticket order
  task automatic test_fifo_order();
    issue_word(OP_ENQ, 32'h7fff_ffff);
    issue_word(OP_ENQ, 32'h8000_0000);
    issue_word(OP_ENQ, 32'h0000_0000);
    issue_word(OP_ENQ, 32'hffff_ffff);
    issue_word(OP_ENQ, 32'h5a5a_a5a5);
    repeat (5) issue_word(OP_DEQ, $urandom());
  endtask

  // dequeue on an empty ring burns its ticket; the enqueue that later gets
  // that ticket is stranded in its cell, which later enqueues must step over
  task automatic test_empty_dequeue();
    issue_word(OP_DEQ, 32'hffff_ffff);
    issue_word(OP_ENQ, pick_value());
    issue_word(OP_ENQ, pick_value());
    issue_word(OP_DEQ, 32'h0000_0000);
  endtask

  // zero limit: enqueue gives up at once with no state change
  task automatic test_probe_limit_zero();
    write_probe_limit('0);
    issue_word(OP_ENQ, pick_value());
    issue_word(OP_ENQ, pick_value());
    write_probe_limit(LIMIT_W'(63));
  endtask

  // fill the whole ring so the tail wraps onto occupied cells, give up full
  // with a limit of 1 and the largest limit, then drain through the gap marks
  task automatic test_ring_overflow();
    write_probe_limit(LIMIT_W'(1));
    repeat (QUEUE_DEPTH + 8) issue_word(OP_ENQ, pick_value());
    write_probe_limit(LIMIT_W'(63));
    repeat (4) issue_word(OP_ENQ, pick_value());
    while ($signed(tail_ticket - head_ticket) > 0) issue_word(OP_DEQ, $urandom());
  endtask

  // mostly well-formed traffic: dequeue only while tickets are outstanding,
  // with a little noise that dequeues ahead of the producer
  task automatic test_random_traffic();
    int unsigned  phase_items [7] = '{150, 150, 150, 30, 150, 150, 150};
    int unsigned  enq_weight  [7] = '{50, 70, 50, 100, 40, 55, 50};
    logic [LIMIT_W-1:0] limit;
    logic         op;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       limit = PROBE_LIMIT_RESET;
        1:       limit = LIMIT_W'(63);
        2:       limit = LIMIT_W'(1);
        3:       limit = '0;
        4:       limit = LIMIT_W'(2);
        5:       limit = LIMIT_W'($urandom_range(3, 62));
        default: limit = LIMIT_W'(63);
      endcase
      write_probe_limit(limit);
      for (int n = 0; n < phase_items[ph]; n++) begin
        if ($urandom_range(0, 99) < 4)
          op = $urandom_range(0, 1) ? OP_DEQ : OP_ENQ;
        else if ($signed(tail_ticket - head_ticket) <= 0)
          op = OP_ENQ;
        else
          op = ($urandom_range(0, 99) < enq_weight[ph]) ? OP_ENQ : OP_DEQ;
        issue_word(op, pick_value());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    ring_clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fifo_order();
    test_empty_dequeue();
    test_probe_limit_zero();
    test_ring_overflow();
    test_random_traffic();

    // drain, then give a late or extra strobe time to show up
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_outcomes.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", awaited_outcomes.size()));

    $display("covered %0d enqueues and %0d dequeues over %0d probe limit writes",
             enq_count, deq_count, limit_writes);
    $display("outcomes: %0d ok, %0d gave up full, %0d gap skips, %0d not ready",
             outcome_tally[ST_OK], outcome_tally[ST_FULL],
             outcome_tally[ST_GAP], outcome_tally[ST_NOT_READY]);
    if (mismatch_count == 0) begin
      $display("ffq_ring_queue_engine regression: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("ffq_ring_queue_engine regression: fail");
    end
    $finish;
  end

endmodule
